### hdl/clfc_pkg.sv
// ----------------------------------------------------------------------------
// clfc_pkg
// Shared types, codes and the CRC-8 byte step for the link frame codec.
// ----------------------------------------------------------------------------
package clfc_pkg;

  localparam logic [7:0] CRC_INIT  = 8'h42;
  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam logic [7:0] SYNC_BYTE = 8'hA5;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = 2;

  typedef enum logic [1:0] {
    REQ_RX_BYTE  = 2'd0,
    REQ_TX_START = 2'd1,
    REQ_TX_BYTE  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    KIND_TX_BYTE = 2'd0,
    KIND_RX_BYTE = 2'd1,
    KIND_VERDICT = 2'd2,
    KIND_REFUSED = 2'd3
  } result_kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SYNC   = 2'd1,
    ST_LENGTH = 2'd2,
    ST_CRC    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HEADER  = 2'd0,
    CMD_PAYLOAD = 2'd1,
    CMD_REFUSE  = 2'd2,
    CMD_VERDICT = 2'd3
  } cmd_kind_t;

  typedef enum logic {
    BK_CMD     = 1'b0,
    BK_RELEASE = 1'b1
  } back_state_t;

  typedef struct packed {
    logic [31:0] tx_total;
    logic [31:0] rx_total;
    logic [31:0] error_total;
    logic [7:0]  recent_opcode;
  } stats_t;

  // One classified transaction handed from the front end to the back end.
  typedef struct packed {
    cmd_kind_t kind;
    logic [7:0] data;
    logic [7:0] crc;
    logic       with_crc;
    status_t    status;
    logic [7:0] opcode;
    logic [7:0] length;
    stats_t     stats;
  } cmd_t;

  // MSB-first CRC-8 update over one byte, no final xor.
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### hdl/clfc_ram.sv
// ----------------------------------------------------------------------------
// clfc_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module clfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/clfc_cmd_queue.sv
// ----------------------------------------------------------------------------
// clfc_cmd_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module clfc_cmd_queue
  import clfc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd,
  output cmd_t rd_cmd,
  output logic empty
);

  cmd_t mem [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_PTR_W:0]   count;
  logic                  do_wr;
  logic                  do_rd;

  assign full   = (count == (CMDQ_PTR_W + 1)'(CMDQ_DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr && !full;
  assign do_rd  = rd && !empty;
  assign rd_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/clfc_front.sv
// ----------------------------------------------------------------------------
// clfc_front
// Accepts input transactions, runs the receive and transmit framing state
// and the counters, buffers received payload and queues back-end commands.
// ----------------------------------------------------------------------------
module clfc_front
  import clfc_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32,
  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        req_type,
  input  logic [7:0]        data_byte,
  input  logic              frame_end,
  input  logic [7:0]        tx_opcode,
  input  logic [7:0]        tx_length,
  input  logic [7:0]        tx_space,
  output logic              cmd_wr,
  output cmd_t              cmd,
  input  logic              cmd_full,
  input  logic              rel_done,
  output logic              ram_wr_en,
  output logic [ADDR_W-1:0] ram_wr_addr,
  output logic [7:0]        ram_wr_data
);

  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  logic [7:0]  rx_position, rx_position_next;
  logic [7:0]  rx_crc, rx_crc_next;
  logic [7:0]  rx_prev, rx_prev_next;
  logic        rx_sync_good, rx_sync_good_next;
  logic [7:0]  rx_opcode, rx_opcode_next;
  logic [7:0]  rx_length, rx_length_next;
  logic        tx_open, tx_open_next;
  logic [7:0]  tx_left, tx_left_next;
  logic [7:0]  tx_crc, tx_crc_next;
  logic [31:0] tx_frames, tx_frames_next;
  logic [31:0] rx_frames, rx_frames_next;
  logic [31:0] err_count, err_count_next;
  logic [7:0]  recent_op, recent_op_next;
  logic        release_busy, release_busy_next;

  logic        accept;
  logic [7:0]  rx_crc_fold;
  logic [7:0]  rx_slot;
  logic [8:0]  rx_len_total;
  logic [8:0]  rx_len_need;
  logic [8:0]  tx_need;
  logic [7:0]  tx_hdr_crc;
  logic [7:0]  tx_byte_crc;

  // A buffered payload must be fully released before its store can be reused.
  assign full   = cmd_full || release_busy;
  assign accept = push && !full;

  assign rx_crc_fold  = crc_fold(rx_crc, rx_prev);
  assign rx_slot      = rx_position - 8'd3;
  assign rx_len_total = {1'b0, rx_position} + 9'd1;
  assign rx_len_need  = {1'b0, rx_length_next} + 9'd4;
  assign tx_need      = {1'b0, tx_length} + 9'd4;
  assign tx_hdr_crc   = crc_fold(crc_fold(CRC_INIT, tx_opcode), tx_length);
  assign tx_byte_crc  = crc_fold(tx_crc, data_byte);

  assign ram_wr_addr = ADDR_W'(rx_slot);
  assign ram_wr_data = data_byte;

  always_comb begin
    rx_position_next  = rx_position;
    rx_crc_next       = rx_crc;
    rx_prev_next      = rx_prev;
    rx_sync_good_next = rx_sync_good;
    rx_opcode_next    = rx_opcode;
    rx_length_next    = rx_length;
    tx_open_next      = tx_open;
    tx_left_next      = tx_left;
    tx_crc_next       = tx_crc;
    tx_frames_next    = tx_frames;
    rx_frames_next    = rx_frames;
    err_count_next    = err_count;
    recent_op_next    = recent_op;
    release_busy_next = release_busy && !rel_done;
    ram_wr_en         = 1'b0;
    cmd_wr            = 1'b0;
    cmd               = '0;

    if (accept) begin
      case (req_t'(req_type))
        REQ_RX_BYTE: begin
          if (rx_position == 8'd0) begin
            rx_sync_good_next = (data_byte == SYNC_BYTE);
            rx_crc_next       = CRC_INIT;
            rx_opcode_next    = 8'd0;
            rx_length_next    = 8'd0;
          end else if (rx_position == 8'd1) begin
            rx_opcode_next = data_byte;
          end else if (rx_position == 8'd2) begin
            rx_length_next = data_byte;
          end else if (rx_slot < MAX_LEN) begin
            ram_wr_en = 1'b1;
          end
          // The CRC lags one byte so that the trailing CRC byte is left out.
          if (rx_position >= 8'd2) begin
            rx_crc_next = rx_crc_fold;
          end
          rx_prev_next = data_byte;

          if (!frame_end) begin
            if (rx_position != 8'hFF) begin
              rx_position_next = rx_position + 8'd1;
            end
          end else begin
            cmd_wr      = 1'b1;
            cmd.kind    = CMD_VERDICT;
            cmd.opcode  = rx_opcode_next;
            cmd.length  = rx_length_next;
            if (!rx_sync_good_next || rx_len_total < 9'd4) begin
              cmd.status = ST_SYNC;
            end else if (rx_length_next > MAX_LEN || rx_len_need != rx_len_total) begin
              cmd.status     = ST_LENGTH;
              err_count_next = err_count + 32'd1;
            end else if (rx_crc_next != data_byte) begin
              cmd.status     = ST_CRC;
              err_count_next = err_count + 32'd1;
            end else begin
              cmd.status     = ST_OK;
              rx_frames_next = rx_frames + 32'd1;
              recent_op_next = rx_opcode_next;
              if (rx_length_next != 8'd0) begin
                release_busy_next = 1'b1;
              end
            end
            rx_position_next = 8'd0;
            rx_crc_next      = CRC_INIT;
          end
        end

        REQ_TX_START: begin
          tx_open_next = 1'b0;
          cmd_wr       = 1'b1;
          if (tx_need > {1'b0, tx_space} || tx_length > MAX_LEN) begin
            cmd.kind = CMD_REFUSE;
          end else begin
            tx_frames_next = tx_frames + 32'd1;
            recent_op_next = tx_opcode;
            tx_crc_next    = tx_hdr_crc;
            cmd.kind       = CMD_HEADER;
            cmd.opcode     = tx_opcode;
            cmd.length     = tx_length;
            cmd.crc        = tx_hdr_crc;
            cmd.with_crc   = (tx_length == 8'd0);
            if (tx_length != 8'd0) begin
              tx_open_next = 1'b1;
              tx_left_next = tx_length;
            end
          end
        end

        REQ_TX_BYTE: begin
          if (tx_open) begin
            tx_crc_next  = tx_byte_crc;
            tx_left_next = tx_left - 8'd1;
            cmd_wr       = 1'b1;
            cmd.kind     = CMD_PAYLOAD;
            cmd.data     = data_byte;
            cmd.crc      = tx_byte_crc;
            cmd.with_crc = (tx_left_next == 8'd0);
            if (tx_left_next == 8'd0) begin
              tx_open_next = 1'b0;
            end
          end
        end

        default: begin
        end
      endcase
    end

    cmd.stats.tx_total      = tx_frames_next;
    cmd.stats.rx_total      = rx_frames_next;
    cmd.stats.error_total   = err_count_next;
    cmd.stats.recent_opcode = recent_op_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_position  <= 8'd0;
      rx_crc       <= CRC_INIT;
      rx_prev      <= 8'd0;
      rx_sync_good <= 1'b0;
      rx_opcode    <= 8'd0;
      rx_length    <= 8'd0;
      tx_open      <= 1'b0;
      tx_left      <= 8'd0;
      tx_crc       <= CRC_INIT;
      tx_frames    <= 32'd0;
      rx_frames    <= 32'd0;
      err_count    <= 32'd0;
      recent_op    <= 8'd0;
      release_busy <= 1'b0;
    end else begin
      rx_position  <= rx_position_next;
      rx_crc       <= rx_crc_next;
      rx_prev      <= rx_prev_next;
      rx_sync_good <= rx_sync_good_next;
      rx_opcode    <= rx_opcode_next;
      rx_length    <= rx_length_next;
      tx_open      <= tx_open_next;
      tx_left      <= tx_left_next;
      tx_crc       <= tx_crc_next;
      tx_frames    <= tx_frames_next;
      rx_frames    <= rx_frames_next;
      err_count    <= err_count_next;
      recent_op    <= recent_op_next;
      release_busy <= release_busy_next;
    end
  end

endmodule

### hdl/clfc_back.sv
// ----------------------------------------------------------------------------
// clfc_back
// Expands queued commands into result transactions: header, payload and CRC
// bytes, refusals, verdicts and the release of a buffered payload.
// ----------------------------------------------------------------------------
module clfc_back
  import clfc_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32,
  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_empty,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  output logic              rel_done,
  output logic              ram_rd_en,
  output logic [ADDR_W-1:0] ram_rd_addr,
  input  logic [7:0]        ram_rd_data,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        result_kind,
  output logic [7:0]        out_byte,
  output logic              is_last,
  output logic [1:0]        status_code,
  output logic [7:0]        frame_opcode,
  output logic [7:0]        frame_length,
  output logic [31:0]       tx_total,
  output logic [31:0]       rx_total,
  output logic [31:0]       error_total,
  output logic [7:0]        recent_opcode
);

  back_state_t       state, state_next;
  logic [1:0]        step, step_next;
  logic [ADDR_W-1:0] rel_idx, rel_idx_next;
  logic              out_valid;
  logic              slot_free;
  logic              load;
  logic              done;
  result_kind_t      r_kind;
  logic [7:0]        r_byte;
  logic              r_last;
  status_t           r_status;
  logic [7:0]        r_opcode;
  logic [7:0]        r_length;

  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_CMD;
      step    <= 2'd0;
      rel_idx <= '0;
    end else begin
      state   <= state_next;
      step    <= step_next;
      rel_idx <= rel_idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    rel_idx_next = rel_idx;
    load         = 1'b0;
    done         = 1'b0;
    rel_done     = 1'b0;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = rel_idx;
    r_kind       = KIND_TX_BYTE;
    r_byte       = 8'd0;
    r_last       = 1'b0;
    r_status     = ST_OK;
    r_opcode     = 8'd0;
    r_length     = 8'd0;

    case (state)
      BK_CMD: begin
        if (!cmd_empty && slot_free) begin
          load = 1'b1;
          case (cmd.kind)
            CMD_HEADER: begin
              case (step)
                2'd0: begin
                  r_byte    = SYNC_BYTE;
                  step_next = 2'd1;
                end
                2'd1: begin
                  r_byte    = cmd.opcode;
                  step_next = 2'd2;
                end
                2'd2: begin
                  r_byte = cmd.length;
                  if (cmd.with_crc) begin
                    step_next = 2'd3;
                  end else begin
                    r_last = 1'b1;
                    done   = 1'b1;
                  end
                end
                default: begin
                  r_byte = cmd.crc;
                  r_last = 1'b1;
                  done   = 1'b1;
                end
              endcase
            end
            CMD_PAYLOAD: begin
              if (step == 2'd0) begin
                r_byte = cmd.data;
                if (cmd.with_crc) begin
                  step_next = 2'd1;
                end else begin
                  r_last = 1'b1;
                  done   = 1'b1;
                end
              end else begin
                r_byte = cmd.crc;
                r_last = 1'b1;
                done   = 1'b1;
              end
            end
            CMD_REFUSE: begin
              r_kind = KIND_REFUSED;
              r_last = 1'b1;
              done   = 1'b1;
            end
            CMD_VERDICT: begin
              r_kind   = KIND_VERDICT;
              r_status = cmd.status;
              r_opcode = cmd.opcode;
              r_length = cmd.length;
              if (cmd.status == ST_OK && cmd.length != 8'd0) begin
                // Fetch the first payload byte while the verdict goes out.
                ram_rd_en    = 1'b1;
                ram_rd_addr  = '0;
                rel_idx_next = '0;
                state_next   = BK_RELEASE;
              end else begin
                r_last = 1'b1;
                done   = 1'b1;
              end
            end
            default: begin
              load = 1'b0;
              done = 1'b1;
            end
          endcase
        end
      end

      BK_RELEASE: begin
        if (slot_free) begin
          load   = 1'b1;
          r_kind = KIND_RX_BYTE;
          r_byte = ram_rd_data;
          if (8'(rel_idx) == cmd.length - 8'd1) begin
            r_last     = 1'b1;
            done       = 1'b1;
            rel_done   = 1'b1;
            state_next = BK_CMD;
          end else begin
            rel_idx_next = rel_idx + 1'b1;
            ram_rd_en    = 1'b1;
            ram_rd_addr  = rel_idx + 1'b1;
          end
        end
      end

      default: begin
        state_next = BK_CMD;
      end
    endcase

    if (done) begin
      step_next = 2'd0;
    end
  end

  assign cmd_pop = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_kind   <= r_kind;
      out_byte      <= r_byte;
      is_last       <= r_last;
      status_code   <= r_status;
      frame_opcode  <= r_opcode;
      frame_length  <= r_length;
      tx_total      <= cmd.stats.tx_total;
      rx_total      <= cmd.stats.rx_total;
      error_total   <= cmd.stats.error_total;
      recent_opcode <= cmd.stats.recent_opcode;
    end
  end

endmodule

### hdl/crc8_link_frame_codec_core.sv
// ----------------------------------------------------------------------------
// crc8_link_frame_codec_core
// Link frame codec: sync 0xA5, opcode, length, payload, CRC-8 (poly 0x07,
// init 0x42). Frames transmit data and checks and deframes received bytes.
//
//   Channel   Handshake        Payload
//   --------  ---------------  ------------------------------------------
//   input     push / full      req_type, data_byte, frame_end, tx_opcode,
//                              tx_length, tx_space
//   results   pop / empty      result_kind, out_byte, is_last, status_code,
//                              frame_opcode, frame_length, tx_total,
//                              rx_total, error_total, recent_opcode
//
// The front end takes one input transaction per cycle while its four-entry
// command queue has room and no payload release is pending. The back end
// issues one result per cycle while its output slot is free: an accepted
// transmit start gives three or four, a refusal one, a verdict with release
// gives 1 + length. After an accepted frame with payload, input is held off
// until the payload store has been read out through the RAM read port.
// Reset is synchronous; the payload store needs no clearing.
// ----------------------------------------------------------------------------
module crc8_link_frame_codec_core
  import clfc_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic [7:0]  data_byte,
  input  logic        frame_end,
  input  logic [7:0]  tx_opcode,
  input  logic [7:0]  tx_length,
  input  logic [7:0]  tx_space,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind,
  output logic [7:0]  out_byte,
  output logic        is_last,
  output logic [1:0]  status_code,
  output logic [7:0]  frame_opcode,
  output logic [7:0]  frame_length,
  output logic [31:0] tx_total,
  output logic [31:0] rx_total,
  output logic [31:0] error_total,
  output logic [7:0]  recent_opcode
);

  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic              q_wr;
  cmd_t              q_wr_cmd;
  logic              q_full;
  logic              q_pop;
  cmd_t              q_head;
  logic              q_empty;
  logic              rel_done;
  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [7:0]        ram_wr_data;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [7:0]        ram_rd_data;

  clfc_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .data_byte  (data_byte),
    .frame_end  (frame_end),
    .tx_opcode  (tx_opcode),
    .tx_length  (tx_length),
    .tx_space   (tx_space),
    .cmd_wr     (q_wr),
    .cmd        (q_wr_cmd),
    .cmd_full   (q_full),
    .rel_done   (rel_done),
    .ram_wr_en  (ram_wr_en),
    .ram_wr_addr(ram_wr_addr),
    .ram_wr_data(ram_wr_data)
  );

  clfc_cmd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wr_cmd(q_wr_cmd),
    .full  (q_full),
    .rd    (q_pop),
    .rd_cmd(q_head),
    .empty (q_empty)
  );

  clfc_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  clfc_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_empty    (q_empty),
    .cmd          (q_head),
    .cmd_pop      (q_pop),
    .rel_done     (rel_done),
    .ram_rd_en    (ram_rd_en),
    .ram_rd_addr  (ram_rd_addr),
    .ram_rd_data  (ram_rd_data),
    .empty        (empty),
    .pop          (pop),
    .result_kind  (result_kind),
    .out_byte     (out_byte),
    .is_last      (is_last),
    .status_code  (status_code),
    .frame_opcode (frame_opcode),
    .frame_length (frame_length),
    .tx_total     (tx_total),
    .rx_total     (rx_total),
    .error_total  (error_total),
    .recent_opcode(recent_opcode)
  );

endmodule

### verif/crc8_link_frame_codec_checker.sv
// ----------------------------------------------------------------------------
// crc8_link_frame_codec_checker
// Watches both queue channels of the link frame codec. It keeps its own copy
// of the receive, transmit and counter state, works out the results of each
// accepted input transaction, and compares every popped result field by field
// with the oldest pending one.
// ----------------------------------------------------------------------------
module crc8_link_frame_codec_checker
  import clfc_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  req_type,
  input  logic [7:0]  data_byte,
  input  logic        frame_end,
  input  logic [7:0]  tx_opcode,
  input  logic [7:0]  tx_length,
  input  logic [7:0]  tx_space,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  result_kind,
  input  logic [7:0]  out_byte,
  input  logic        is_last,
  input  logic [1:0]  status_code,
  input  logic [7:0]  frame_opcode,
  input  logic [7:0]  frame_length,
  input  logic [31:0] tx_total,
  input  logic [31:0] rx_total,
  input  logic [31:0] error_total,
  input  logic [7:0]  recent_opcode,
  output int          mismatch_count,
  output int          results_pending
);

  typedef struct {
    result_kind_t kind;
    logic [7:0]   data;
    logic         last;
    status_t      status;
    logic [7:0]   opcode;
    logic [7:0]   length;
    logic [31:0]  tx_count;
    logic [31:0]  rx_count;
    logic [31:0]  err_count;
    logic [7:0]   recent;
  } link_result_t;

  link_result_t expected_results[$];
  link_result_t oldest;

  // Receive side.
  logic [7:0]  rx_pos;
  logic [7:0]  rx_crc;
  logic [7:0]  rx_prev;
  logic        rx_sync_ok;
  logic [7:0]  rx_op;
  logic [7:0]  rx_len;
  logic [7:0]  rx_store [MAX_PAYLOAD];
  // Transmit side.
  logic        tx_open;
  logic [7:0]  tx_left;
  logic [7:0]  tx_crc;
  // Counters.
  logic [31:0] tx_frames;
  logic [31:0] rx_frames;
  logic [31:0] rx_errors;
  logic [7:0]  last_op;

  function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] b);
    logic [7:0] acc;
    acc = crc ^ b;
    repeat (8) acc = acc[7] ? ({acc[6:0], 1'b0} ^ CRC_POLY) : {acc[6:0], 1'b0};
    return acc;
  endfunction

  // Counters are captured as they stand after the item has updated them.
  function automatic void add_result(result_kind_t kind, logic [7:0] data, status_t status,
                                     logic [7:0] opcode, logic [7:0] length);
    link_result_t r;
    r.kind      = kind;
    r.data      = data;
    r.last      = 1'b0;
    r.status    = status;
    r.opcode    = opcode;
    r.length    = length;
    r.tx_count  = tx_frames;
    r.rx_count  = rx_frames;
    r.err_count = rx_errors;
    r.recent    = last_op;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_item(logic [1:0] req, logic [7:0] b, logic fin,
                                       logic [7:0] op, logic [7:0] len, logic [7:0] space);
    int           pos;
    int           base;
    status_t      verdict;
    link_result_t r;
    base = expected_results.size();
    case (req)
      REQ_RX_BYTE: begin
        pos = int'(rx_pos);
        if (pos == 0) begin
          rx_sync_ok = (b == SYNC_BYTE);
          rx_crc     = CRC_INIT;
          rx_op      = 8'h00;
          rx_len     = 8'h00;
        end else if (pos == 1) begin
          rx_op = b;
        end else if (pos == 2) begin
          rx_len = b;
        end else if (pos - 3 < MAX_PAYLOAD) begin
          rx_store[pos - 3] = b;
        end
        // The CRC trails by one byte so that the last byte is never folded in.
        if (pos >= 2) rx_crc = crc8_next(rx_crc, rx_prev);
        rx_prev = b;
        if (!fin) begin
          if (pos < 255) rx_pos = rx_pos + 8'd1;
        end else begin
          if (!rx_sync_ok || pos + 1 < 4) begin
            verdict = ST_SYNC;
          end else if (int'(rx_len) > MAX_PAYLOAD || int'(rx_len) + 4 != pos + 1) begin
            verdict   = ST_LENGTH;
            rx_errors = rx_errors + 32'd1;
          end else if (rx_crc != b) begin
            verdict   = ST_CRC;
            rx_errors = rx_errors + 32'd1;
          end else begin
            verdict   = ST_OK;
            rx_frames = rx_frames + 32'd1;
            last_op   = rx_op;
          end
          add_result(KIND_VERDICT, 8'h00, verdict, rx_op, rx_len);
          if (verdict == ST_OK) begin
            for (int i = 0; i < int'(rx_len) && i < MAX_PAYLOAD; i++) begin
              add_result(KIND_RX_BYTE, rx_store[i], ST_OK, 8'h00, 8'h00);
            end
          end
          rx_pos = 8'h00;
          rx_crc = CRC_INIT;
        end
      end
      REQ_TX_START: begin
        tx_open = 1'b0;
        if (int'(len) + 4 > int'(space) || int'(len) > MAX_PAYLOAD) begin
          add_result(KIND_REFUSED, 8'h00, ST_OK, 8'h00, 8'h00);
        end else begin
          tx_frames = tx_frames + 32'd1;
          last_op   = op;
          tx_crc    = crc8_next(crc8_next(CRC_INIT, op), len);
          add_result(KIND_TX_BYTE, SYNC_BYTE, ST_OK, 8'h00, 8'h00);
          add_result(KIND_TX_BYTE, op, ST_OK, 8'h00, 8'h00);
          add_result(KIND_TX_BYTE, len, ST_OK, 8'h00, 8'h00);
          if (len == 8'h00) begin
            add_result(KIND_TX_BYTE, tx_crc, ST_OK, 8'h00, 8'h00);
          end else begin
            tx_open = 1'b1;
            tx_left = len;
          end
        end
      end
      REQ_TX_BYTE: begin
        if (tx_open) begin
          tx_crc = crc8_next(tx_crc, b);
          add_result(KIND_TX_BYTE, b, ST_OK, 8'h00, 8'h00);
          tx_left = tx_left - 8'd1;
          if (tx_left == 8'h00) begin
            add_result(KIND_TX_BYTE, tx_crc, ST_OK, 8'h00, 8'h00);
            tx_open = 1'b0;
          end
        end
      end
      default: ;
    endcase
    if (expected_results.size() > base) begin
      r = expected_results.pop_back();
      r.last = 1'b1;
      expected_results.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rx_pos     = 8'h00;
      rx_crc     = CRC_INIT;
      rx_prev    = 8'h00;
      rx_sync_ok = 1'b0;
      rx_op      = 8'h00;
      rx_len     = 8'h00;
      tx_open    = 1'b0;
      tx_left    = 8'h00;
      tx_crc     = CRC_INIT;
      tx_frames  = 32'd0;
      rx_frames  = 32'd0;
      rx_errors  = 32'd0;
      last_op    = 8'h00;
      expected_results.delete();
    end else begin
      // A result popped at this edge can only stem from an earlier transaction.
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing pending: expected none, actual kind %0d byte %0h",
                   $time, result_kind, out_byte);
          mismatch_count++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("result_kind", 32'(oldest.kind), 32'(result_kind));
          check_field("out_byte", 32'(oldest.data), 32'(out_byte));
          check_field("is_last", 32'(oldest.last), 32'(is_last));
          check_field("status_code", 32'(oldest.status), 32'(status_code));
          check_field("frame_opcode", 32'(oldest.opcode), 32'(frame_opcode));
          check_field("frame_length", 32'(oldest.length), 32'(frame_length));
          check_field("tx_total", oldest.tx_count, tx_total);
          check_field("rx_total", oldest.rx_count, rx_total);
          check_field("error_total", oldest.err_count, error_total);
          check_field("recent_opcode", 32'(oldest.recent), 32'(recent_opcode));
        end
      end
      if (push && !full) begin
        predict_item(req_type, data_byte, frame_end, tx_opcode, tx_length, tx_space);
      end
    end
    results_pending = expected_results.size();
  end

endmodule

### verif/crc8_link_frame_codec_core_tb.sv
// ----------------------------------------------------------------------------
// crc8_link_frame_codec_core_tb
// Drives transmit starts, transmit payload bytes and received link bytes into
// the codec: a directed pass over the corner cases, a back-pressure phase,
// then random frames with random flaws and noise. The checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module crc8_link_frame_codec_core_tb
  import clfc_pkg::*;
();

  localparam int         MAX_PAYLOAD  = 32;
  localparam logic [1:0] REQ_RESERVED = 2'd3;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         RANDOM_ITEMS = 50;

  typedef enum {
    FLAW_NONE,
    FLAW_SYNC,
    FLAW_SHORT,
    FLAW_LENGTH,
    FLAW_OVERSIZE,
    FLAW_CRC,
    FLAW_OVERLONG
  } frame_flaw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  req_type = REQ_RX_BYTE;
  logic [7:0]  data_byte = 8'h00;
  logic        frame_end = 1'b0;
  logic [7:0]  tx_opcode = 8'h00;
  logic [7:0]  tx_length = 8'h00;
  logic [7:0]  tx_space = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  result_kind;
  logic [7:0]  out_byte;
  logic        is_last;
  logic [1:0]  status_code;
  logic [7:0]  frame_opcode;
  logic [7:0]  frame_length;
  logic [31:0] tx_total;
  logic [31:0] rx_total;
  logic [31:0] error_total;
  logic [7:0]  recent_opcode;
  int          mismatch_count;
  int          results_pending;

  // Sender and receiver pacing.
  int burst_left = 0;
  bit steady = 1'b0;
  int items_sent = 0;
  bit hold_request = 1'b0;
  bit hold_served = 1'b0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int pop_tick = 0;

  crc8_link_frame_codec_core #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (.*);

  crc8_link_frame_codec_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) link_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 4);
    if (r < 9) return $urandom_range(5, 16);
    return MAX_PAYLOAD;
  endfunction

  // Offers one transaction and returns at the edge where it is accepted.
  // push stays high so that back-to-back transactions need no toggle.
  task automatic offer(input logic [1:0] req, input logic [7:0] b, input logic fin,
                       input logic [7:0] op, input logic [7:0] len, input logic [7:0] space,
                       input bit counted);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) begin
        gap = $urandom_range(1, 6);
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push      <= 1'b1;
    req_type  <= req;
    data_byte <= b;
    frame_end <= fin;
    tx_opcode <= op;
    tx_length <= len;
    tx_space  <= space;
    @(posedge clk);
    while (full) @(posedge clk);
    if (counted) items_sent++;
  endtask

  task automatic send_rx_frame(input logic [7:0] op, input int len, input frame_flaw_t flaw);
    logic [7:0] link_bytes[$];
    logic [7:0] crc;
    logic [7:0] len_byte;
    logic [7:0] b;
    int         count;
    int         keep;
    len_byte = 8'(len);
    count    = len;
    case (flaw)
      FLAW_LENGTH:   count = (len > 0 && $urandom_range(0, 1) == 1) ? len - 1 : len + 1;
      FLAW_OVERSIZE: len_byte = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
      FLAW_OVERLONG: count = MAX_PAYLOAD + 6;
      default: ;
    endcase
    b = SYNC_BYTE;
    if (flaw == FLAW_SYNC) begin
      b = rnd8();
      if (b == SYNC_BYTE) b = 8'h00;
    end
    link_bytes.push_back(b);
    link_bytes.push_back(op);
    link_bytes.push_back(len_byte);
    crc = crc_fold(crc_fold(CRC_INIT, op), len_byte);
    repeat (count) begin
      b = rnd8();
      link_bytes.push_back(b);
      crc = crc_fold(crc, b);
    end
    if (flaw == FLAW_CRC) crc = crc ^ 8'($urandom_range(1, 255));
    link_bytes.push_back(crc);
    if (flaw == FLAW_SHORT) begin
      keep = $urandom_range(1, 3);
      while (link_bytes.size() > keep) void'(link_bytes.pop_back());
    end
    foreach (link_bytes[i]) begin
      offer(REQ_RX_BYTE, link_bytes[i], i == link_bytes.size() - 1, rnd8(), rnd8(), rnd8(),
            1'b1);
    end
  endtask

  // live tells whether the start is expected to open a frame, so that ignored
  // payload bytes are not counted.
  task automatic send_tx_frame(input logic [7:0] op, input int len, input int space,
                               input int sent, input bit live);
    offer(REQ_TX_START, rnd8(), 1'($urandom_range(0, 1)), op, 8'(len), 8'(space), 1'b1);
    for (int i = 0; i < sent; i++) begin
      offer(REQ_TX_BYTE, rnd8(), 1'($urandom_range(0, 1)), rnd8(), rnd8(), rnd8(),
            live && i < len);
    end
  endtask

  task automatic send_noise();
    logic [1:0] req;
    logic       fin;
    bit         rx_open;
    int         k;
    rx_open = 1'b0;
    k = $urandom_range(1, 4);
    repeat (k) begin
      req = 2'($urandom_range(0, 3));
      fin = 1'($urandom_range(0, 1));
      offer(req, rnd8(), fin, rnd8(), rnd8(), rnd8(),
            req == REQ_RX_BYTE || req == REQ_TX_START);
      if (req == REQ_RX_BYTE) rx_open = !fin;
    end
    // Close any partial receive so that the next frame starts on its sync byte.
    if (rx_open) offer(REQ_RX_BYTE, rnd8(), 1'b1, rnd8(), rnd8(), rnd8(), 1'b1);
  endtask

  task automatic random_scenario();
    int  sel;
    int  len;
    int  space;
    int  sent;
    int  r;
    bit  live;
    frame_flaw_t flaw;
    sel = $urandom_range(0, 99);
    steady = ($urandom_range(0, 5) == 0);
    if (sel < 45) begin
      flaw = FLAW_NONE;
      if ($urandom_range(0, 99) >= 65) flaw = frame_flaw_t'($urandom_range(1, 5));
      send_rx_frame(rnd8(), pick_length(), flaw);
    end else if (sel < 85) begin
      len = pick_length();
      if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 255);
      if ($urandom_range(0, 4) != 0) space = $urandom_range(len + 4 > 255 ? 255 : len + 4, 255);
      else space = $urandom_range(0, 255);
      live = (len <= MAX_PAYLOAD && len + 4 <= space);
      sent = (len > MAX_PAYLOAD) ? $urandom_range(0, 2) : len;
      r = $urandom_range(0, 19);
      if (r == 0 && sent > 0) sent = $urandom_range(0, sent - 1);
      else if (r == 1) sent = sent + $urandom_range(1, 3);
      send_tx_frame(rnd8(), len, space, sent, live);
    end else begin
      send_noise();
    end
  endtask

  // Receiver: changing stall patterns, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (hold_request && !hold_served) begin
      hold_served = 1'b1;
      hold_left = HOLD_CYCLES;
      pop <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      pop_tick++;
      case (stall_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= (pop_tick % 3 != 0);
        default: pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Transmit corners: empty payload at exact fit, byte extremes, refusals.
    send_tx_frame(8'h00, 0, 4, 0, 1'b1);
    offer(REQ_TX_START, 8'h00, 1'b0, 8'hFF, 8'd2, 8'd6, 1'b1);
    offer(REQ_TX_BYTE, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1);
    offer(REQ_TX_BYTE, 8'hFF, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_tx_frame(8'h11, 33, 255, 0, 1'b0);
    send_tx_frame(8'h22, 251, 255, 0, 1'b0);
    send_tx_frame(8'h33, 2, 5, 0, 1'b0);
    send_tx_frame(8'h44, 0, 0, 0, 1'b0);
    // A new start abandons the frame that is still open.
    send_tx_frame(8'h3C, 3, 20, 1, 1'b1);
    send_tx_frame(8'hC3, 1, 255, 1, 1'b1);
    // Ignored: payload with no open frame, and the unused request code.
    offer(REQ_TX_BYTE, 8'h5A, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
    offer(REQ_RESERVED, 8'hA5, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    // Receive verdicts.
    send_rx_frame(8'h00, 1, FLAW_NONE);
    send_rx_frame(8'hFF, 0, FLAW_NONE);
    send_rx_frame(8'h12, 2, FLAW_SHORT);
    send_rx_frame(8'h34, 0, FLAW_SYNC);
    send_rx_frame(8'h56, 1, FLAW_OVERSIZE);
    send_rx_frame(8'h78, 1, FLAW_CRC);
    send_rx_frame(8'h9A, 0, FLAW_LENGTH);

    // Back pressure: the receiver holds off while the sender keeps offering.
    steady = 1'b1;
    hold_request = 1'b1;
    repeat (3) send_tx_frame(rnd8(), 6, 255, 6, 1'b1);
    send_rx_frame(rnd8(), 8, FLAW_NONE);
    steady = 1'b0;

    // Full-size frames both ways, then the random mix.
    send_tx_frame(rnd8(), MAX_PAYLOAD, 255, MAX_PAYLOAD, 1'b1);
    send_rx_frame(rnd8(), MAX_PAYLOAD, FLAW_NONE);
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) random_scenario();

    // An overlong receive runs past the payload store; the next frame must recover.
    send_rx_frame(rnd8(), $urandom_range(0, MAX_PAYLOAD), FLAW_OVERLONG);
    send_rx_frame(rnd8(), 3, FLAW_NONE);

    push <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (results_pending != 0) begin
      $display("%0t: %0d expected results never arrived", $time, results_pending);
    end
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("crc8_link_frame_codec_core_tb: PASS");
    end else begin
      $display("crc8_link_frame_codec_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("crc8_link_frame_codec_core_tb: FAIL");
    $finish;
  end

endmodule
